// ----- rtl/lorentz_boost_momentum_macros.svh -----
// Assertion helpers for the boost datapath
`ifndef LORENTZ_BOOST_MOMENTUM_MACROS_SVH
`define LORENTZ_BOOST_MOMENTUM_MACROS_SVH

// same-cycle implication
`define LBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lbm_pkg.sv -----
package lbm_pkg;

  localparam int unsigned IN_W       = 224;
  localparam int unsigned OUT_W      = 104;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned BACK_STAGES = 11;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BETA = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [61:0] ONE_Q60   = 62'h1000000000000000;
  localparam logic [40:0] T_LIM     = 41'h10000000000;
  localparam logic [63:0] TWO_P63   = 64'h8000000000000000;
  localparam logic [63:0] ONE_Q32   = 64'h0000000100000000;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][30:0] b;
    logic             bad;
    logic             bzero;
    logic             bp_neg;
    logic [63:0]      bp_mag;
    logic [31:0]      e;
    logic [31:0]      s;
    logic [63:0]      g;
    logic [63:0]      g2;
  } item_t;

endpackage

// ----- rtl/lbm_front.sv -----
module lbm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2:0][31:0] in_p,
  input  logic [30:0]      in_m,
  input  logic [2:0][30:0] in_b,
  output logic             out_vld,
  output lbm_pkg::item_t   out_item,
  output logic [63:0]      out_rad_e,
  output logic [63:0]      out_rad_s
);

  logic             vld1_r;
  logic [2:0][31:0] p_r;
  logic [2:0][30:0] b_r;
  logic [2:0][63:0] sqp_r;
  logic [61:0]      sqm_r;
  logic [2:0][61:0] sqb_r;
  logic [2:0][63:0] pb_r;

  logic             vld2_r;
  lbm_pkg::item_t   item_r;
  lbm_pkg::item_t   item_nxt;
  logic [63:0]      rad_e_r;
  logic [63:0]      rad_e_nxt;
  logic [63:0]      rad_s_r;
  logic [63:0]      rad_s_nxt;

  logic [61:0]      b2;
  logic [61:0]      d;
  logic [63:0]      bp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= in_p;
      b_r   <= in_b;
      sqm_r <= 62'(in_m * in_m);
      for (int c = 0; c < 3; c++) begin
        sqp_r[c] <= 64'($signed(in_p[c]) * $signed(in_p[c]));
        sqb_r[c] <= 62'($signed(in_b[c]) * $signed(in_b[c]));
        pb_r[c]  <= 64'($signed(in_b[c]) * $signed(in_p[c]));
      end
    end
  end

  always_comb begin
    b2  = sqb_r[0] + sqb_r[1] + sqb_r[2];
    d   = lbm_pkg::ONE_Q60 - b2;
    bp  = pb_r[0] + pb_r[1] + pb_r[2];
    item_nxt        = '0;
    item_nxt.p      = p_r;
    item_nxt.b      = b_r;
    item_nxt.bad    = b2 >= lbm_pkg::ONE_Q60;
    item_nxt.bzero  = b2 == '0;
    item_nxt.bp_neg = bp[63];
    item_nxt.bp_mag = bp[63] ? (~bp + 64'd1) : bp;
    rad_e_nxt = sqp_r[0] + sqp_r[1] + sqp_r[2] + {2'b00, sqm_r};
    rad_s_nxt = {d, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r  <= item_nxt;
      rad_e_r <= rad_e_nxt;
      rad_s_r <= rad_s_nxt;
    end
  end

  assign out_vld   = vld2_r;
  assign out_item  = item_r;
  assign out_rad_e = rad_e_r;
  assign out_rad_s = rad_s_r;

endmodule

// ----- rtl/lbm_sqrt2.sv -----
module lbm_sqrt2 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  lbm_pkg::item_t in_item,
  input  logic [63:0]    in_rad_a,
  input  logic [63:0]    in_rad_b,
  output logic           out_vld,
  output lbm_pkg::item_t out_item,
  output logic [31:0]    out_root_a,
  output logic [31:0]    out_root_b
);

  localparam int unsigned N = lbm_pkg::SQRT_STEPS;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t x);
    logic [35:0] rem2;
    logic [35:0] trial;
    sq_t         y;
    rem2  = {x.rem, x.rad[63:62]};
    trial = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      y.rem  = 34'(rem2 - trial);
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = rem2[33:0];
      y.root = {x.root[30:0], 1'b0};
    end
    return y;
  endfunction

  logic [N-1:0]   vld_r;
  lbm_pkg::item_t item_r [N];
  sq_t            a_r [N];
  sq_t            b_r [N];
  sq_t            a_in;
  sq_t            b_in;

  assign a_in = '{rad: in_rad_a, rem: '0, root: '0};
  assign b_in = '{rad: in_rad_b, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      a_r[0]    <= sq_step(a_in);
      b_r[0]    <= sq_step(b_in);
      for (int k = 1; k < N; k++) begin
        item_r[k] <= item_r[k-1];
        a_r[k]    <= sq_step(a_r[k-1]);
        b_r[k]    <= sq_step(b_r[k-1]);
      end
    end
  end

  assign out_vld    = vld_r[N-1];
  assign out_item   = item_r[N-1];
  assign out_root_a = a_r[N-1].root;
  assign out_root_b = b_r[N-1].root;

endmodule

// ----- rtl/lbm_div.sv -----
module lbm_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  lbm_pkg::item_t in_item,
  input  logic [63:0]    in_hi,
  input  logic [63:0]    in_lo,
  input  logic [63:0]    in_den,
  output logic           out_vld,
  output lbm_pkg::item_t out_item,
  output logic [63:0]    out_quo
);

  localparam int unsigned N = lbm_pkg::DIV_STEPS;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lq;
    logic [63:0] den;
  } dv_t;

  function automatic dv_t dv_step(dv_t x);
    logic [64:0] rem2;
    logic        qb;
    dv_t         y;
    rem2  = {x.rem, x.lq[63]};
    qb    = rem2 >= {1'b0, x.den};
    y.rem = qb ? 64'(rem2 - {1'b0, x.den}) : rem2[63:0];
    y.lq  = {x.lq[62:0], qb};
    y.den = x.den;
    return y;
  endfunction

  logic [N-1:0]   vld_r;
  lbm_pkg::item_t item_r [N];
  dv_t            st_r [N];
  dv_t            st_in;

  assign st_in = '{rem: in_hi, lq: in_lo, den: in_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      st_r[0]   <= dv_step(st_in);
      for (int k = 1; k < N; k++) begin
        item_r[k] <= item_r[k-1];
        st_r[k]   <= dv_step(st_r[k-1]);
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_item = item_r[N-1];
  assign out_quo  = st_r[N-1].lq;

endmodule

// ----- rtl/lbm_gsq.sv -----
module lbm_gsq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  lbm_pkg::item_t in_item,
  output logic           out_vld,
  output lbm_pkg::item_t out_item,
  output logic [63:0]    out_hi,
  output logic [63:0]    out_lo,
  output logic [63:0]    out_den
);

  logic           vld1_r;
  logic           vld2_r;
  lbm_pkg::item_t item1_r;
  lbm_pkg::item_t item2_r;
  logic [63:0]    hh_r;
  logic [63:0]    hl_r;
  logic [63:0]    ll_r;
  logic [127:0]   sq_r;
  logic [63:0]    den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= in_item;
      hh_r    <= 64'(in_item.g[63:32]) * 64'(in_item.g[63:32]);
      hl_r    <= 64'(in_item.g[63:32]) * 64'(in_item.g[31:0]);
      ll_r    <= 64'(in_item.g[31:0]) * 64'(in_item.g[31:0]);
      item2_r <= item1_r;
      sq_r    <= {hh_r, ll_r} + {31'b0, hl_r, 33'b0};
      den_r   <= item1_r.g + lbm_pkg::ONE_Q32;
    end
  end

  assign out_vld  = vld2_r;
  assign out_item = item2_r;
  assign out_hi   = sq_r[127:64];
  assign out_lo   = sq_r[63:0];
  assign out_den  = den_r;

endmodule

// ----- rtl/lbm_back.sv -----
module lbm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  lbm_pkg::item_t   in_item,
  output logic             out_vld,
  output logic [2:0][31:0] out_mom,
  output logic [1:0]       out_status
);

  localparam int unsigned NS = lbm_pkg::BACK_STAGES;

  logic [NS-1:0]    vld_r;
  logic             out_vld_r;

  lbm_pkg::item_t   it1_r, it2_r, it3_r, it4_r, it5_r, it6_r;
  lbm_pkg::item_t   it7_r, it8_r, it9_r, it10_r, it11_r;

  logic [63:0]      p00_r, p01_r, p10_r, p11_r, ge0_r, ge1_r;
  logic [64:0]      mid_r;
  logic [127:0]     t1b_r;
  logic [95:0]      tg_r;
  logic [127:0]     term1_r;
  logic [95:0]      tg3_r;
  logic [127:0]     f_r;
  logic             fneg_r;
  logic [127:0]     fmag_r;
  logic [2:0]       neg6_r, neg7_r, neg8_r, neg9_r, neg10_r;
  logic [3:0][62:0] q_r [3];
  logic [95:0]      lo_r [3];
  logic [95:0]      hi_r [3];
  logic [159:0]     pr_r [3];
  logic [68:0]      tm_r [3];
  logic [40:0]      tc_r [3];
  logic [42:0]      sum_r [3];
  logic [2:0][31:0] mom_r;
  logic [1:0]       status_r;

  logic [127:0]     tg_sh;
  logic [30:0]      bmag [3];
  logic [2:0][31:0] mom_nxt;
  logic [1:0]       status_nxt;
  logic             sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NS-2:0], in_vld};
      out_vld_r <= vld_r[NS-1];
    end
  end

  always_comb begin
    tg_sh = {2'b00, tg3_r, 30'b0};
    for (int c = 0; c < 3; c++) begin
      bmag[c] = it5_r.b[c][30] ? (~it5_r.b[c] + 31'd1) : it5_r.b[c];
    end
  end

  always_comb begin
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if ($signed(sum_r[c]) > $signed(43'sh00_7FFF_FFFF)) begin
        mom_nxt[c] = 32'h7FFF_FFFF;
        sat        = 1'b1;
      end else if ($signed(sum_r[c]) < -$signed(43'sh00_8000_0000)) begin
        mom_nxt[c] = 32'h8000_0000;
        sat        = 1'b1;
      end else begin
        mom_nxt[c] = sum_r[c][31:0];
      end
    end
    if (it11_r.bad) begin
      mom_nxt    = it11_r.p;
      status_nxt = lbm_pkg::ST_BETA;
    end else if (sat) begin
      status_nxt = lbm_pkg::ST_SAT;
    end else begin
      status_nxt = lbm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      p00_r <= 64'(in_item.g2[31:0]) * 64'(in_item.bp_mag[31:0]);
      p01_r <= 64'(in_item.g2[31:0]) * 64'(in_item.bp_mag[63:32]);
      p10_r <= 64'(in_item.g2[63:32]) * 64'(in_item.bp_mag[31:0]);
      p11_r <= 64'(in_item.g2[63:32]) * 64'(in_item.bp_mag[63:32]);
      ge0_r <= 64'(in_item.g[31:0]) * 64'(in_item.e);
      ge1_r <= 64'(in_item.g[63:32]) * 64'(in_item.e);

      it2_r <= it1_r;
      mid_r <= 65'(p01_r) + 65'(p10_r);
      t1b_r <= {p11_r, p00_r};
      tg_r  <= {ge1_r, 32'b0} + {32'b0, ge0_r};

      it3_r   <= it2_r;
      term1_r <= t1b_r + {31'b0, mid_r, 32'b0};
      tg3_r   <= tg_r;

      it4_r <= it3_r;
      f_r   <= it3_r.bp_neg ? (tg_sh - term1_r) : (tg_sh + term1_r);

      it5_r  <= it4_r;
      fneg_r <= f_r[127];
      fmag_r <= f_r[127] ? (~f_r + 128'd1) : f_r;

      it6_r <= it5_r;
      for (int c = 0; c < 3; c++) begin
        neg6_r[c] <= it5_r.b[c][30] ^ fneg_r;
        for (int k = 0; k < 4; k++) begin
          q_r[c][k] <= 63'(fmag_r[32*k +: 32]) * 63'(bmag[c]);
        end
      end

      it7_r  <= it6_r;
      neg7_r <= neg6_r;
      for (int c = 0; c < 3; c++) begin
        lo_r[c] <= {q_r[c][1], 32'b0} + {33'b0, q_r[c][0]};
        hi_r[c] <= {q_r[c][3], 32'b0} + {33'b0, q_r[c][2]};
      end

      it8_r  <= it7_r;
      neg8_r <= neg7_r;
      for (int c = 0; c < 3; c++) begin
        pr_r[c] <= {64'b0, lo_r[c]} + {hi_r[c], 64'b0};
      end

      it9_r  <= it8_r;
      neg9_r <= neg8_r;
      for (int c = 0; c < 3; c++) begin
        tm_r[c] <= {1'b0, pr_r[c][159:92]} + 69'(neg8_r[c] && (|pr_r[c][91:0]));
      end

      it10_r  <= it9_r;
      neg10_r <= neg9_r;
      for (int c = 0; c < 3; c++) begin
        tc_r[c] <= (tm_r[c] > {28'b0, lbm_pkg::T_LIM}) ? lbm_pkg::T_LIM : tm_r[c][40:0];
      end

      it11_r <= it10_r;
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= neg10_r[c] ?
                    (43'($signed(it10_r.p[c])) - {2'b00, tc_r[c]}) :
                    (43'($signed(it10_r.p[c])) + {2'b00, tc_r[c]});
      end

      mom_r    <= mom_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_mom    = mom_r;
  assign out_status = status_r;

endmodule

// ----- rtl/lorentz_boost_momentum.sv -----
// Relativistic boost of a particle momentum by velocity beta, one particle per clock when the
// result side keeps up. In order, the pipeline forms the squares and sums, runs the dual
// square-root pipeline (energy and sqrt(1 - beta^2) together), divides for gamma =
// 1/sqrt(1 - beta^2), squares gamma, divides for (gamma - 1)/beta^2, and forms the wide
// products, the final shift and saturation, plus the output register. The whole pipeline
// advances together whenever the output register is empty or being read, so a stall on the
// result side holds every stage. Status is 1 when |beta| is not below one (momentum passes
// through), 2 when a component clamps to the 32-bit range, else 0.
`include "lorentz_boost_momentum_macros.svh"

module lorentz_boost_momentum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // mom_x[31:0], mom_y[63:32], mom_z[95:64], rest_mass[126:96],
  // beta_x[157:127], beta_y[188:158], beta_z[219:189], zero pad
  input  logic [lbm_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], status[97:96], zero pad
  output logic [lbm_pkg::OUT_W-1:0]    out_tdata
);

  logic             en;
  logic [2:0][31:0] in_p;
  logic [30:0]      in_m;
  logic [2:0][30:0] in_b;

  logic             fr_vld;
  lbm_pkg::item_t   fr_item;
  logic [63:0]      fr_rad_e;
  logic [63:0]      fr_rad_s;

  logic             sq_vld;
  lbm_pkg::item_t   sq_item;
  logic [31:0]      sq_root_e;
  logic [31:0]      sq_root_s;
  lbm_pkg::item_t   sq_item_upd;

  logic             gd_vld;
  lbm_pkg::item_t   gd_item;
  logic [63:0]      gd_quo;
  lbm_pkg::item_t   gd_item_upd;

  logic             gs_vld;
  lbm_pkg::item_t   gs_item;
  logic [63:0]      gs_hi;
  logic [63:0]      gs_lo;
  logic [63:0]      gs_den;

  logic             g2_vld;
  lbm_pkg::item_t   g2_item;
  logic [63:0]      g2_quo;
  lbm_pkg::item_t   g2_item_upd;

  logic             bk_vld;
  logic [2:0][31:0] bk_mom;
  logic [1:0]       bk_status;
  logic             sat_at_bound;

  assign en        = !bk_vld || out_tready;
  assign in_tready = en && rst_n;

  assign in_p[0] = in_tdata[31:0];
  assign in_p[1] = in_tdata[63:32];
  assign in_p[2] = in_tdata[95:64];
  assign in_m    = in_tdata[126:96];
  assign in_b[0] = in_tdata[157:127];
  assign in_b[1] = in_tdata[188:158];
  assign in_b[2] = in_tdata[219:189];

  lbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid),
    .in_p      (in_p),
    .in_m      (in_m),
    .in_b      (in_b),
    .out_vld   (fr_vld),
    .out_item  (fr_item),
    .out_rad_e (fr_rad_e),
    .out_rad_s (fr_rad_s)
  );

  lbm_sqrt2 u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (fr_vld),
    .in_item    (fr_item),
    .in_rad_a   (fr_rad_e),
    .in_rad_b   (fr_rad_s),
    .out_vld    (sq_vld),
    .out_item   (sq_item),
    .out_root_a (sq_root_e),
    .out_root_b (sq_root_s)
  );

  always_comb begin
    sq_item_upd   = sq_item;
    sq_item_upd.e = sq_root_e;
    sq_item_upd.s = sq_root_s;
  end

  lbm_div u_gamma (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_item  (sq_item_upd),
    .in_hi    (64'd0),
    .in_lo    (lbm_pkg::TWO_P63),
    .in_den   ({32'b0, sq_root_s}),
    .out_vld  (gd_vld),
    .out_item (gd_item),
    .out_quo  (gd_quo)
  );

  always_comb begin
    gd_item_upd   = gd_item;
    gd_item_upd.g = gd_quo;
  end

  lbm_gsq u_gsq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (gd_vld),
    .in_item  (gd_item_upd),
    .out_vld  (gs_vld),
    .out_item (gs_item),
    .out_hi   (gs_hi),
    .out_lo   (gs_lo),
    .out_den  (gs_den)
  );

  lbm_div u_gamma2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (gs_vld),
    .in_item  (gs_item),
    .in_hi    (gs_hi),
    .in_lo    (gs_lo),
    .in_den   (gs_den),
    .out_vld  (g2_vld),
    .out_item (g2_item),
    .out_quo  (g2_quo)
  );

  always_comb begin
    g2_item_upd    = g2_item;
    g2_item_upd.g2 = g2_item.bzero ? 64'd0 : g2_quo;
  end

  lbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (g2_vld),
    .in_item    (g2_item_upd),
    .out_vld    (bk_vld),
    .out_mom    (bk_mom),
    .out_status (bk_status)
  );

  assign out_tvalid = bk_vld;
  assign out_tdata  = {6'b0, bk_status, bk_mom[2], bk_mom[1], bk_mom[0]};

  assign sat_at_bound = bk_mom[0] == 32'h7FFF_FFFF || bk_mom[0] == 32'h8000_0000 ||
                        bk_mom[1] == 32'h7FFF_FFFF || bk_mom[1] == 32'h8000_0000 ||
                        bk_mom[2] == 32'h7FFF_FFFF || bk_mom[2] == 32'h8000_0000;

  `LBM_ASSERT_IMP(a_status_code, bk_vld, bk_status != 2'b11, "undefined status code")
  `LBM_ASSERT_IMP(a_sat_bound, bk_vld && bk_status == lbm_pkg::ST_SAT, sat_at_bound, "no clamp")
  `LBM_ASSERT_NXT(a_stall_hold, bk_vld && !out_tready, $stable(sq_vld) && $stable(g2_vld), "moved")

endmodule

// ----- tb/sv/tb_lorentz_boost_momentum.sv -----
module tb_lorentz_boost_momentum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RAND = 440;
  localparam int TAIL = 60;
  localparam int DRAIN = 260;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [63:0] UNIT_Q60 = 64'h1000_0000_0000_0000;

  typedef struct {
    logic signed [31:0] mom [3];
    logic [30:0] mass;
    logic signed [30:0] beta [3];
  } particle_t;

  typedef struct {
    logic signed [31:0] mom [3];
    logic [1:0] status;
  } boosted_t;

  typedef struct {
    particle_t part;
    bit known;
    boosted_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [lbm_pkg::IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [lbm_pkg::OUT_W-1:0] out_tdata;

  boosted_t boosted_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  lorentz_boost_momentum dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic boosted_t boost(particle_t pt);
    boosted_t r;
    logic signed [63:0] p [3];
    logic signed [63:0] b [3];
    logic [63:0] b2, esq, energy, sroot, gam, gam2, msq;
    logic [127:0] gsq;
    logic signed [63:0] bdotp, shift, total;
    logic signed [191:0] wg2, wbp, wg, we, fw, tw, lim;
    for (int c = 0; c < 3; c++) begin
      p[c] = pt.mom[c];
      b[c] = pt.beta[c];
      r.mom[c] = pt.mom[c];
    end
    b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
    if (b2 >= UNIT_Q60) begin
      r.status = lbm_pkg::ST_BETA;
      return r;
    end
    r.status = lbm_pkg::ST_OK;
    msq = {33'b0, pt.mass} * {33'b0, pt.mass};
    esq = p[0] * p[0] + p[1] * p[1] + p[2] * p[2] + msq;
    energy = floor_sqrt(esq);
    sroot = floor_sqrt((UNIT_Q60 - b2) << 2);
    gam = 64'h8000_0000_0000_0000 / sroot;
    if (b2 == 0) begin
      gam2 = 0;
    end else begin
      gsq = {64'b0, gam} * {64'b0, gam};
      gam2 = 64'(gsq / ({64'b0, gam} + 128'h1_0000_0000));
    end
    bdotp = b[0] * p[0] + b[1] * p[1] + b[2] * p[2];
    wg2 = {128'b0, gam2};
    wbp = bdotp;
    wg = {128'b0, gam};
    we = {128'b0, energy};
    fw = wg2 * wbp + ((wg * we) <<< 30);
    lim = 192'sd1 <<< 40;
    for (int c = 0; c < 3; c++) begin
      tw = b[c];
      tw = (tw * fw) >>> 92;
      if (tw > lim) tw = lim;
      else if (tw < -lim) tw = -lim;
      shift = tw[63:0];
      total = p[c] + shift;
      if (total > 64'sd2147483647) begin
        total = 64'sd2147483647;
        r.status = lbm_pkg::ST_SAT;
      end else if (total < -64'sd2147483648) begin
        total = -64'sd2147483648;
        r.status = lbm_pkg::ST_SAT;
      end
      r.mom[c] = total[31:0];
    end
    return r;
  endfunction

  function automatic vector_t vec(logic signed [31:0] px, logic signed [31:0] py,
                                  logic signed [31:0] pz, logic [30:0] m,
                                  logic signed [30:0] bx, logic signed [30:0] by,
                                  logic signed [30:0] bz, bit known = 1'b0,
                                  logic signed [31:0] ox = 0, logic signed [31:0] oy = 0,
                                  logic signed [31:0] oz = 0,
                                  logic [1:0] st = lbm_pkg::ST_OK);
    vector_t v;
    v.part.mom[0] = px; v.part.mom[1] = py; v.part.mom[2] = pz;
    v.part.mass = m;
    v.part.beta[0] = bx; v.part.beta[1] = by; v.part.beta[2] = bz;
    v.known = known;
    v.want.mom[0] = ox; v.want.mom[1] = oy; v.want.mom[2] = oz;
    v.want.status = st;
    return v;
  endfunction

  function automatic particle_t random_particle();
    particle_t pt;
    int mode;
    mode = $urandom_range(0, 9);
    for (int c = 0; c < 3; c++) begin
      if ($urandom_range(0, 3) == 0) pt.mom[c] = $urandom;
      else pt.mom[c] = $signed($urandom) >>> $urandom_range(4, 20);
      if (mode < 7) pt.beta[c] = 31'($signed($urandom) >>> $urandom_range(3, 12));
      else if (mode == 7) pt.beta[c] = 31'($signed($urandom) >>> $urandom_range(8, 20));
      else pt.beta[c] = 31'($urandom);
    end
    if (mode == 7) begin
      pt.beta[0] = 31'sd1073741824 - 31'($urandom_range(1, 1 << 20));
      if ($urandom_range(0, 1)) pt.beta[0] = -pt.beta[0];
    end
    pt.mass = 31'($urandom >> $urandom_range(1, 21));
    return pt;
  endfunction

  initial begin
    vector_t dir [$];
    vector_t v;
    boosted_t want;
    int total;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    dir.insert(dir.size(), vec(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, lbm_pkg::ST_OK));
    dir.insert(dir.size(), vec(32'sh7FFF_FFFF, 32'sh8000_0000, -1, 31'h7FFF_FFFF, 0, 0, 0, 1,
                               32'sh7FFF_FFFF, 32'sh8000_0000, -1, lbm_pkg::ST_OK));
    dir.insert(dir.size(), vec(123, -456, 789, 1000, 31'sh4000_0000, 0, 0, 1,
                               123, -456, 789, lbm_pkg::ST_BETA));
    dir.insert(dir.size(), vec(5, 6, 7, 8, 31'sh3FFF_FFFF, 31'sh3FFF_FFFF, 0, 1, 5, 6, 7,
                               lbm_pkg::ST_BETA));
    dir.insert(dir.size(), vec(-9, 10, -11, 12, 31'sh3FFF_FFFF, 31'sh3FFF_FFFF, 31'sh3FFF_FFFF,
                               1, -9, 10, -11, lbm_pkg::ST_BETA));
    dir.insert(dir.size(), vec(32'sh7FFF_FFFF, 0, 0, 0, 31'sh3FFF_FFFF, 0, 0, 1,
                               32'sh7FFF_FFFF, 0, 0, lbm_pkg::ST_SAT));
    dir.insert(dir.size(), vec(32'sh8000_0000, 0, 0, 0, -31'sh3FFF_FFFF, 0, 0, 1,
                               32'sh8000_0000, 0, 0, lbm_pkg::ST_SAT));
    dir.insert(dir.size(), vec(0, 0, 0, 31'h0001_0000, 31'sh2000_0000, 0, 0));
    dir.insert(dir.size(), vec(0, 0, 0, 31'h7FFF_FFFF, 0, 31'sh3FFF_FFFF, 0));
    dir.insert(dir.size(), vec(0, 0, 0, 31'h7FFF_FFFF, 0, 0, -31'sh3FFF_FFFF));
    dir.insert(dir.size(), vec(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 31'h0000_8000,
                               31'sh2000_0000, 31'sh2000_0000, 31'sh2000_0000));
    dir.insert(dir.size(), vec(-32'sh0010_0000, 32'sh0000_4000, 32'sh0123_4567, 31'h0005_0000,
                               -31'sh1000_0000, 31'sh0800_0000, -31'sh2000_0000));
    dir.insert(dir.size(), vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                               31'sh0000_0001, -31'sh0000_0001, 31'sh0000_0001));
    dir.insert(dir.size(), vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                               31'sh2000_0000, 31'sh2000_0000, 31'sh2000_0000));
    dir.insert(dir.size(), vec(32'sh0000_1000, 0, 0, 31'h0000_1000, 31'sh3FFF_0000,
                               31'sh0100_0000, 0));
    total = dir.size() + N_RAND;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < total; i++) begin
      if (i < dir.size()) begin
        v = dir[i];
      end else begin
        v.part = random_particle();
        v.known = 1'b0;
      end
      want = v.known ? v.want : boost(v.part);
      quiet = (i >= total - TAIL);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= {4'b0, v.part.beta[2], v.part.beta[1], v.part.beta[0], v.part.mass,
                   v.part.mom[2], v.part.mom[1], v.part.mom[0]};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      boosted_q.insert(boosted_q.size(), want);
    end
    in_tvalid <= 1'b0;
    while (boosted_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    boosted_t want;
    boosted_t got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got.mom[0] = out_tdata[31:0];
        got.mom[1] = out_tdata[63:32];
        got.mom[2] = out_tdata[95:64];
        got.status = out_tdata[97:96];
        if (boosted_q.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %0d %0d %0d status %0d",
                   $realtime, got.mom[0], got.mom[1], got.mom[2], got.status);
          errors++;
        end else begin
          want = boosted_q.pop_front();
          for (int c = 0; c < 3; c++)
            if (got.mom[c] !== want.mom[c]) begin
              $display("%0t: out[%0d] expected %0d actual %0d", $realtime, c,
                       want.mom[c], got.mom[c]);
              errors++;
            end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     want.status, got.status);
            errors++;
          end
        end
      end
    end
  end

endmodule
